### hw/rtl/dswc_pkg.sv
// ----------------------------------------------------------------------------
// Dice sum ways counter package
// Shared constants, payload types and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package dswc_pkg;

    localparam int MAX_TARGET = 255;
    localparam int MAX_DICE   = 64;
    localparam int MAX_FACES  = 64;

    localparam int FACES_W  = 7;
    localparam int DICE_W   = 7;
    localparam int TARGET_W = 8;
    localparam int COUNT_W  = 64;

    localparam int ROW_DEPTH = MAX_TARGET + 1;
    localparam int ADDR_W    = $clog2(ROW_DEPTH);

    typedef struct packed {
        logic [FACES_W-1:0]  faces;
        logic [DICE_W-1:0]   dice_count;
        logic [TARGET_W-1:0] target_sum;
    } t_req;

    typedef struct packed {
        logic [COUNT_W-1:0] way_count;
        logic               status;
    } t_rsp;

    typedef struct packed {
        logic                step_valid;
        logic [TARGET_W-1:0] step_s;
        logic                step_die1;
        logic                step_phase;
        logic                step_last;
        logic [FACES_W-1:0]  faces;
        logic                res_set;
        logic                res_value;
        logic                res_status;
        logic                out_load;
    } t_dp_cmd;

endpackage

### hw/rtl/dswc_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
interface dswc_req_if;
    import dswc_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/dswc_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one response word.
// ----------------------------------------------------------------------------
interface dswc_rsp_if;
    import dswc_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/dswc_ctrl.sv
// ----------------------------------------------------------------------------
// Dice sum ways controller
// Handshakes both channels and sequences one row entry per cycle.
// ----------------------------------------------------------------------------
module dswc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dswc_pkg::t_req    i_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dswc_pkg::t_dp_cmd o_cmd
);
    import dswc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [TARGET_W-1:0] r_s, n_s;
    logic [DICE_W-1:0]   r_die, n_die;
    logic                r_phase, n_phase;
    logic                r_out_valid, n_out_valid;
    logic [FACES_W-1:0]  r_faces, n_faces;
    logic [DICE_W-1:0]   r_dice, n_dice;
    logic [TARGET_W-1:0] r_target, n_target;

    logic w_accept;
    logic w_err;
    logic w_trivial;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_err     = (int'(i_req.faces) > MAX_FACES) || (int'(i_req.dice_count) > MAX_DICE)
                       || (int'(i_req.target_sum) > MAX_TARGET);
    assign w_trivial = (i_req.dice_count == '0) || (i_req.target_sum == '0);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state  = r_state;
        n_s      = r_s;
        n_die    = r_die;
        n_phase  = r_phase;
        n_faces  = r_faces;
        n_dice   = r_dice;
        n_target = r_target;

        o_cmd            = '0;
        o_cmd.step_s     = r_s;
        o_cmd.step_die1  = (r_die == DICE_W'(1));
        o_cmd.step_phase = r_phase;
        o_cmd.faces      = r_faces;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_faces  = i_req.faces;
                    n_dice   = i_req.dice_count;
                    n_target = i_req.target_sum;
                    n_s      = TARGET_W'(1);
                    n_die    = DICE_W'(1);
                    n_phase  = 1'b0;
                    if (w_err || w_trivial) begin
                        o_cmd.res_set    = 1'b1;
                        o_cmd.res_value  = !w_err && (i_req.dice_count == '0)
                                           && (i_req.target_sum == '0);
                        o_cmd.res_status = w_err;
                        n_state          = ST_FIN;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.step_valid = 1'b1;
                o_cmd.step_last  = (r_s == r_target) && (r_die == r_dice);
                if (r_s == r_target) begin
                    n_s     = TARGET_W'(1);
                    n_die   = r_die + DICE_W'(1);
                    n_phase = !r_phase;
                    if (r_die == r_dice) begin
                        n_state = ST_DRAIN;
                    end
                end else begin
                    n_s = r_s + TARGET_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_s         <= TARGET_W'(1);
            r_die       <= DICE_W'(1);
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_s         <= n_s;
            r_die       <= n_die;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_faces  <= n_faces;
        r_dice   <= n_dice;
        r_target <= n_target;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_s != '0) && (r_s <= r_target)
                                && (r_die != '0) && (r_die <= r_dice))
        else $error("Row counters left the request bounds.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_err) |=> (r_state == ST_FIN))
        else $error("Out-of-range request did not go straight to the result.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("Response word raised outside the result state.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> $past(o_cmd.step_last))
        else $error("Drain entered without the final row entry.");

endmodule

### hw/rtl/dswc_dp.sv
// ----------------------------------------------------------------------------
// Dice sum ways datapath
// Two ping-pong row memories, a sliding window accumulator and the result.
// ----------------------------------------------------------------------------
module dswc_dp (
    input  logic                        i_clk,
    input  dswc_pkg::t_dp_cmd           i_cmd,
    output logic [dswc_pkg::COUNT_W-1:0] o_way_count,
    output logic                        o_status
);
    import dswc_pkg::*;

    logic [COUNT_W-1:0] r_mem0 [ROW_DEPTH];
    logic [COUNT_W-1:0] r_mem1 [ROW_DEPTH];

    logic [TARGET_W-1:0] w_s_m1;
    logic [TARGET_W:0]   w_diff;
    logic [ADDR_W-1:0]   w_a1;
    logic [ADDR_W-1:0]   w_a2;

    logic [COUNT_W-1:0] r_rd0_a, r_rd0_b, r_rd1_a, r_rd1_b;
    logic               r_b_valid;
    logic               r_b_first, r_b_die1, r_b_phase, r_b_last;
    logic               r_b_zero1, r_b_zero2, r_b_sub;
    logic [ADDR_W-1:0]  r_b_addr;

    logic [COUNT_W-1:0] w_d1, w_d2, w_p1, w_p2, w_base, n_w;
    logic [COUNT_W-1:0] r_w;
    logic [COUNT_W-1:0] r_res;
    logic               r_res_status;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_status;

    assign w_s_m1 = i_cmd.step_s - TARGET_W'(1);
    assign w_diff = {1'b0, w_s_m1} - (TARGET_W+1)'(i_cmd.faces);
    assign w_a1   = w_s_m1[ADDR_W-1:0];
    assign w_a2   = w_diff[ADDR_W-1:0];

    // Entry zero of the previous row and the whole first row come from the
    // cleared-table rule, so those reads never depend on the memories.
    assign w_d1   = r_b_phase ? r_rd1_a : r_rd0_a;
    assign w_d2   = r_b_phase ? r_rd1_b : r_rd0_b;
    assign w_p1   = r_b_zero1 ? COUNT_W'(r_b_die1) : (r_b_die1 ? '0 : w_d1);
    assign w_p2   = r_b_zero2 ? COUNT_W'(r_b_die1) : (r_b_die1 ? '0 : w_d2);
    assign w_base = r_b_first ? '0 : r_w;
    assign n_w    = w_base + w_p1 - (r_b_sub ? w_p2 : '0);

    always_ff @(posedge i_clk) begin
        r_rd0_a <= r_mem0[w_a1];
        r_rd0_b <= r_mem0[w_a2];
        if (r_b_valid && r_b_phase) begin
            r_mem0[r_b_addr] <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd1_a <= r_mem1[w_a1];
        r_rd1_b <= r_mem1[w_a2];
        if (r_b_valid && !r_b_phase) begin
            r_mem1[r_b_addr] <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_valid <= i_cmd.step_valid;
        r_b_first <= (i_cmd.step_s == TARGET_W'(1));
        r_b_die1  <= i_cmd.step_die1;
        r_b_phase <= i_cmd.step_phase;
        r_b_last  <= i_cmd.step_last;
        r_b_zero1 <= (w_s_m1 == '0);
        r_b_zero2 <= (w_diff == '0);
        r_b_sub   <= !w_diff[TARGET_W];
        r_b_addr  <= i_cmd.step_s[ADDR_W-1:0];

        if (r_b_valid) begin
            r_w <= n_w;
        end

        if (i_cmd.res_set) begin
            r_res        <= COUNT_W'(i_cmd.res_value);
            r_res_status <= i_cmd.res_status;
        end else if (r_b_valid && r_b_last) begin
            r_res        <= n_w;
            r_res_status <= 1'b0;
        end

        if (i_cmd.out_load) begin
            r_out_count  <= r_res;
            r_out_status <= r_res_status;
        end
    end

    assign o_way_count = r_out_count;
    assign o_status    = r_out_status;

endmodule

### hw/rtl/dice_sum_ways_counter.sv
// ----------------------------------------------------------------------------
// Dice sum ways counter
// A request walks the row entries die by die, each up to the target sum, then
// drains and loads the response word; out of range, no dice or a zero target
// loads it directly. One row entry per cycle through a two-port read of the
// previous-row memory. A new request is taken only once the response register
// is loaded, which waits for an untaken response. Reset clears control only.
// ----------------------------------------------------------------------------
module dice_sum_ways_counter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dswc_req_if.sink  i_req,
    dswc_rsp_if.source o_rsp
);
    import dswc_pkg::*;

    t_dp_cmd            w_cmd;
    logic [COUNT_W-1:0] w_way_count;
    logic               w_status;

    dswc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_req       (i_req.payload),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    dswc_dp u_dp (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .o_way_count (w_way_count),
        .o_status    (w_status)
    );

    assign o_rsp.payload.way_count = w_way_count;
    assign o_rsp.payload.status    = w_status;

endmodule
